/* hdl/url_percent_decoder_assert.svh */
// Assertion macros for the URL percent decoder checker.
// Used by url_pct_checker.sv; no other dependencies.
`ifndef URL_PERCENT_DECODER_ASSERT_SVH
`define URL_PERCENT_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define URL_PCT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define URL_PCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/url_pct_pkg.sv */
// Shared types and constants for the URL percent decoder.
// No dependencies; used by the front, queue, back and top-level modules and the testbench.
`timescale 1ns / 1ps

package url_pct_pkg;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // characters of interest
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;

   // 'a'..'f' / 'A'..'F': low nibble 1..6 plus this gives 10..15
   localparam logic [3:0] HEX_LETTER_OFFSET = 4'd9;

   // byte class worked out by the front
   typedef enum logic [1:0] {
      CLS_PLAIN,
      CLS_PERCENT,
      CLS_HEX
   } class_type;

   // escape sequence progress
   typedef enum logic [1:0] {
      PH_OUTSIDE,
      PH_FIRST,
      PH_SECOND
   } phase_type;

   // classified item as held in the queue
   typedef struct packed {
      logic [7:0] data;     // byte to pass through, '+' already mapped to space
      logic [3:0] nibble;   // hex value when cls is CLS_HEX
      class_type  cls;
      logic       eos;
   } item_type;

endpackage

/* hdl/url_pct_front.sv */
// Front end: accepts raw bytes and classifies them for the decoder.
// Depends on url_pct_pkg.
`timescale 1ns / 1ps

module url_pct_front (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_in_byte,
   input  logic                  req_end_of_string,
   input  logic                  queue_full,
   output logic                  push,
   output url_pct_pkg::item_type push_item
);

   // stall only on a full queue
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // classify the byte
   always_comb begin
      push_item.data   = req_in_byte;
      push_item.nibble = req_in_byte[3:0];
      push_item.cls    = url_pct_pkg::CLS_PLAIN;
      push_item.eos    = req_end_of_string;

      if (req_in_byte == url_pct_pkg::CHAR_PLUS) begin
         push_item.data = url_pct_pkg::CHAR_SPACE;
      end

      if (req_in_byte == url_pct_pkg::CHAR_PERCENT) begin
         push_item.cls = url_pct_pkg::CLS_PERCENT;
      end else if (req_in_byte inside {[8'h30:8'h39]}) begin
         push_item.cls = url_pct_pkg::CLS_HEX;
      end else if (req_in_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         push_item.cls    = url_pct_pkg::CLS_HEX;
         push_item.nibble = req_in_byte[3:0] + url_pct_pkg::HEX_LETTER_OFFSET;
      end
   end

endmodule

/* hdl/url_pct_queue.sv */
// Short FIFO of classified items between front and back.
// Depends on url_pct_pkg.
`timescale 1ns / 1ps

module url_pct_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  url_pct_pkg::item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output url_pct_pkg::item_type pop_item,
   output logic                  empty
);

   url_pct_pkg::item_type               entries_ff [url_pct_pkg::QUEUE_DEPTH];
   logic [url_pct_pkg::QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [url_pct_pkg::QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [url_pct_pkg::QUEUE_AW:0]      count_ff, count_in;

   assign full     = (count_ff == (url_pct_pkg::QUEUE_AW+1)'(url_pct_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = entries_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* hdl/url_pct_back.sv */
// Back end: escape state machine and registered result stage.
// Depends on url_pct_pkg.
`timescale 1ns / 1ps

module url_pct_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  queue_empty,
   input  url_pct_pkg::item_type item,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_byte_valid,
   output logic                  rsp_is_last,
   output logic                  rsp_decode_error
);

   url_pct_pkg::phase_type phase_ff, phase_in;
   logic [3:0]             high_ff, high_in;
   logic                   err_ff, err_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             byte_ff, byte_in;
   logic                   bvalid_ff, bvalid_in;
   logic                   last_ff, last_in;
   logic                   derr_ff, derr_in;

   logic                   emit;

   // take an item when the result register is free or being drained
   assign pop = !queue_empty && (!rsp_valid_ff || !rsp_stall);

   // next state and result
   always_comb begin
      phase_in  = phase_ff;
      high_in   = high_ff;
      err_in    = err_ff;
      emit      = 1'b0;
      byte_in   = '0;
      bvalid_in = 1'b0;
      last_in   = 1'b0;
      derr_in   = 1'b0;

      if (pop) begin
         if (err_ff) begin
            // dropping until end of string
            if (item.eos) begin
               emit    = 1'b1;
               last_in = 1'b1;
               derr_in = 1'b1;
            end
         end else begin
            case (phase_ff)
               url_pct_pkg::PH_FIRST: begin
                  if (item.cls == url_pct_pkg::CLS_HEX) begin
                     high_in  = item.nibble;
                     phase_in = url_pct_pkg::PH_SECOND;
                  end else begin
                     err_in   = 1'b1;
                     phase_in = url_pct_pkg::PH_OUTSIDE;
                  end
                  if (item.eos) begin
                     emit    = 1'b1;
                     last_in = 1'b1;
                     derr_in = 1'b1;
                  end
               end
               url_pct_pkg::PH_SECOND: begin
                  phase_in = url_pct_pkg::PH_OUTSIDE;
                  if (item.cls == url_pct_pkg::CLS_HEX) begin
                     emit      = 1'b1;
                     byte_in   = {high_ff, item.nibble};
                     bvalid_in = 1'b1;
                     last_in   = item.eos;
                  end else begin
                     err_in = 1'b1;
                     if (item.eos) begin
                        emit    = 1'b1;
                        last_in = 1'b1;
                        derr_in = 1'b1;
                     end
                  end
               end
               default: begin
                  // outside an escape
                  phase_in = url_pct_pkg::PH_OUTSIDE;
                  if (item.cls == url_pct_pkg::CLS_PERCENT) begin
                     phase_in = url_pct_pkg::PH_FIRST;
                     if (item.eos) begin
                        emit    = 1'b1;
                        last_in = 1'b1;
                        derr_in = 1'b1;
                     end
                  end else begin
                     emit      = 1'b1;
                     byte_in   = item.data;
                     bvalid_in = 1'b1;
                     last_in   = item.eos;
                  end
               end
            endcase
         end

         // closing result starts a fresh string
         if (emit && last_in) begin
            phase_in = url_pct_pkg::PH_OUTSIDE;
            high_in  = '0;
            err_in   = 1'b0;
         end
      end

      // result register valid
      if (pop) begin
         rsp_valid_in = emit;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= url_pct_pkg::PH_OUTSIDE;
         high_ff      <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         high_ff      <= high_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded with each emitted item
   always_ff @(posedge clock) begin
      if (pop && emit) begin
         byte_ff   <= byte_in;
         bvalid_ff <= bvalid_in;
         last_ff   <= last_in;
         derr_ff   <= derr_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_byte_valid   = bvalid_ff;
   assign rsp_is_last      = last_ff;
   assign rsp_decode_error = derr_ff;

endmodule

/* hdl/url_percent_decoder.sv */
// URL percent decoder top level: front classifier, item queue, back decoder.
// Depends on url_pct_pkg, url_pct_front, url_pct_queue, url_pct_back.
`timescale 1ns / 1ps

// Streaming URL / form decoder taking one raw byte per cycle. Plain bytes pass
// through ('+' becomes a space), "%hh" yields the encoded byte, and a bad or
// truncated escape gives a single closing item with decode_error set (bytes in
// between are dropped). Every end-of-string byte gives exactly one item with
// is_last set; error items carry byte_valid 0 and out_byte 0. A new byte is
// taken every cycle while the four-entry queue between classifier and decoder
// has room; each accepted byte is written into the queue and then decoded into
// the output register, from which its result shows on rsp_valid. With the result
// side stalled, one result waits in the output register and four bytes in the
// queue before req_stall is raised.
module url_percent_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_string,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_is_last,
   output logic       rsp_decode_error
);

   logic                  push;
   logic                  pop;
   logic                  queue_full;
   logic                  queue_empty;
   url_pct_pkg::item_type push_item;
   url_pct_pkg::item_type pop_item;

   url_pct_front u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .queue_full        (queue_full),
      .push              (push),
      .push_item         (push_item)
   );

   url_pct_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .pop_item  (pop_item),
      .empty     (queue_empty)
   );

   url_pct_back u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_empty      (queue_empty),
      .item             (pop_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_is_last      (rsp_is_last),
      .rsp_decode_error (rsp_decode_error)
   );

endmodule

/* hdl/url_pct_checker.sv */
// Port-level checks for the URL percent decoder, bound to the top level.
// Depends on url_percent_decoder_assert.svh.
`timescale 1ns / 1ps
`include "url_percent_decoder_assert.svh"

module url_pct_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_is_last,
   input logic       rsp_decode_error
);

   // a stalled result holds
   `URL_PCT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable({rsp_out_byte, rsp_byte_valid, rsp_is_last, rsp_decode_error}), "stalled result changed")

   // an error only ever closes a string and carries no byte
   `URL_PCT_ASSERT_SAME(a_err_closes, clock, reset, rsp_valid && rsp_decode_error, rsp_is_last && !rsp_byte_valid, "error item not a bare closing item")

   // an item without a byte shows a zero byte
   `URL_PCT_ASSERT_SAME(a_no_byte_zero, clock, reset, rsp_valid && !rsp_byte_valid, rsp_out_byte == 8'h00, "empty item carries a byte")

   // every item either carries a byte or closes the string with an error
   `URL_PCT_ASSERT_SAME(a_item_useful, clock, reset, rsp_valid, rsp_byte_valid || (rsp_is_last && rsp_decode_error), "item with neither byte nor error")

endmodule

bind url_percent_decoder url_pct_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_out_byte     (rsp_out_byte),
   .rsp_byte_valid   (rsp_byte_valid),
   .rsp_is_last      (rsp_is_last),
   .rsp_decode_error (rsp_decode_error)
);

/* tb/sv/url_percent_decoder_test.sv */
// Self-checking testbench for url_percent_decoder: directed table, then random strings.
// Depends on url_pct_pkg and the url_percent_decoder RTL; results are checked against a local decoder and the table.
`timescale 1ns / 1ps

module url_percent_decoder_test;

   // one decoded item as seen on the rsp_ side
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       is_last;
      logic       decode_error;
   } decoded_type;

   // how a directed row is checked
   typedef enum logic [1:0] {
      ROW_PREDICT,   // expectation from the local decoder
      ROW_SILENT,    // no item may come out for this byte
      ROW_TYPED      // expectation written into the table
   } row_kind_type;

   typedef struct packed {
      logic [7:0]   in_byte;
      logic         eos;
      row_kind_type kind;
      decoded_type  res;
   } stim_row_type;

   localparam decoded_type CLOSE_ERROR  = '{8'h00, 1'b0, 1'b1, 1'b1};
   localparam decoded_type NO_ITEM      = '{8'h00, 1'b0, 1'b0, 1'b0};
   localparam int          NUM_DIRECTED = 23;
   localparam int          NUM_ITEMS    = 1450;
   localparam int          IDLE_PCT     = 7;
   localparam int          HOLD_CYCLES  = 80;

   // directed strings: extremes, '+', escapes in both cases, bad and truncated escapes
   localparam stim_row_type DIRECTED_ROWS [0:NUM_DIRECTED-1] = '{
      '{8'h00, 1'b0, ROW_TYPED,   '{8'h00, 1'b1, 1'b0, 1'b0}},
      '{8'hFF, 1'b1, ROW_TYPED,   '{8'hFF, 1'b1, 1'b1, 1'b0}},
      '{"+",   1'b0, ROW_TYPED,   '{8'h20, 1'b1, 1'b0, 1'b0}},
      '{"%",   1'b0, ROW_SILENT,  NO_ITEM},
      '{"4",   1'b0, ROW_SILENT,  NO_ITEM},
      '{"1",   1'b0, ROW_PREDICT, NO_ITEM},
      '{"%",   1'b0, ROW_SILENT,  NO_ITEM},
      '{"f",   1'b0, ROW_SILENT,  NO_ITEM},
      '{"F",   1'b0, ROW_PREDICT, NO_ITEM},
      '{"%",   1'b0, ROW_SILENT,  NO_ITEM},
      '{"9",   1'b0, ROW_SILENT,  NO_ITEM},
      '{"A",   1'b1, ROW_PREDICT, NO_ITEM},
      // bad first digit, then dropped bytes up to the end of the string
      '{"%",   1'b0, ROW_SILENT,  NO_ITEM},
      '{"g",   1'b0, ROW_SILENT,  NO_ITEM},
      '{"%",   1'b0, ROW_SILENT,  NO_ITEM},
      '{"y",   1'b1, ROW_TYPED,   CLOSE_ERROR},
      // bad second digit on the last byte
      '{"%",   1'b0, ROW_SILENT,  NO_ITEM},
      '{"a",   1'b0, ROW_SILENT,  NO_ITEM},
      '{"G",   1'b1, ROW_TYPED,   CLOSE_ERROR},
      // string ends on '%' and on the first digit
      '{"%",   1'b1, ROW_TYPED,   CLOSE_ERROR},
      '{"%",   1'b0, ROW_SILENT,  NO_ITEM},
      '{"3",   1'b1, ROW_TYPED,   CLOSE_ERROR},
      '{"+",   1'b1, ROW_TYPED,   '{8'h20, 1'b1, 1'b1, 1'b0}}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_end_of_string = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_is_last;
   logic       rsp_decode_error;

   decoded_type pending_results[$];
   int          mismatches  = 0;
   int          bytes_sent  = 0;
   int          tx_idle_pct = IDLE_PCT;
   int          rx_idle_pct = IDLE_PCT;
   bit          hold_go     = 1'b0;

   // local decoder state
   url_pct_pkg::phase_type dec_phase = url_pct_pkg::PH_OUTSIDE;
   logic [3:0]             dec_high  = 4'h0;
   logic                   dec_err   = 1'b0;

   url_percent_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_is_last       (rsp_is_last),
      .rsp_decode_error  (rsp_decode_error)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hex digit value; bit 4 set when the byte is not a digit
   function automatic logic [4:0] hex_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
      if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 10)};
      if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 10)};
      return 5'h10;
   endfunction

   // one byte through the local decoder; emit says whether an item results
   function automatic void decode_byte(input logic [7:0] b, input logic eos,
                                       output logic emit, output decoded_type res);
      logic [4:0] d;
      d    = hex_of(b);
      emit = eos;
      res  = CLOSE_ERROR;
      if (!dec_err) begin
         case (dec_phase)
            url_pct_pkg::PH_FIRST: begin
               if (d[4]) begin
                  dec_err   = 1'b1;
                  dec_phase = url_pct_pkg::PH_OUTSIDE;
               end else begin
                  dec_high  = d[3:0];
                  dec_phase = url_pct_pkg::PH_SECOND;
               end
            end
            url_pct_pkg::PH_SECOND: begin
               dec_phase = url_pct_pkg::PH_OUTSIDE;
               if (d[4]) begin
                  dec_err = 1'b1;
               end else begin
                  emit = 1'b1;
                  res  = '{{dec_high, d[3:0]}, 1'b1, eos, 1'b0};
               end
            end
            default: begin
               // outside an escape; the unused phase code behaves the same
               dec_phase = url_pct_pkg::PH_OUTSIDE;
               if (b == url_pct_pkg::CHAR_PERCENT) begin
                  dec_phase = url_pct_pkg::PH_FIRST;
               end else begin
                  emit = 1'b1;
                  res  = '{(b == url_pct_pkg::CHAR_PLUS) ? url_pct_pkg::CHAR_SPACE : b,
                           1'b1, eos, 1'b0};
               end
            end
         endcase
      end
      // closing item returns to the idle state for the next string
      if (emit && res.is_last) begin
         dec_phase = url_pct_pkg::PH_OUTSIDE;
         dec_high  = 4'h0;
         dec_err   = 1'b0;
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // offer one item, with random idle cycles first; returns once accepted
   task automatic send_item(input logic [7:0] b, input logic eos, input row_kind_type kind,
                            input decoded_type typed);
      logic        emit;
      decoded_type res;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_in_byte       <= b;
      req_end_of_string <= eos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      decode_byte(b, eos, emit, res);
      if (kind == ROW_TYPED) pending_results.push_back(typed);
      else if (kind == ROW_PREDICT && emit) pending_results.push_back(res);
   endtask

   function automatic logic [7:0] rand_hex_digit();
      int v;
      v = $urandom_range(15);
      if (v < 10) return 8'("0" + v);
      return 8'(($urandom_range(1) ? "a" : "A") + v - 10);
   endfunction

   function automatic logic [7:0] rand_non_hex();
      logic [7:0] b;
      logic [4:0] h;
      b = 8'($urandom_range(255));
      h = hex_of(b);
      while (!h[4]) begin
         b = 8'($urandom_range(255));
         h = hex_of(b);
      end
      return b;
   endfunction

   // receiver: random stalls, plus one long hold-off to fill the block
   initial begin : receiver
      int hold_left;
      bit hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
         end else if (hold_go && !hold_taken) begin
            hold_left  = HOLD_CYCLES;
            hold_taken = 1'b1;
         end
         rsp_stall <= (hold_left > 0) || ($urandom_range(99) < rx_idle_pct);
      end
   end

   // result check against the oldest expectation
   always @(posedge clock) begin
      decoded_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected item", rsp_out_byte, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_out_byte != want.out_byte)
               report_mismatch("out_byte", rsp_out_byte, want.out_byte);
            if (rsp_byte_valid != want.byte_valid)
               report_mismatch("byte_valid", rsp_byte_valid, want.byte_valid);
            if (rsp_is_last != want.is_last)
               report_mismatch("is_last", rsp_is_last, want.is_last);
            if (rsp_decode_error != want.decode_error)
               report_mismatch("decode_error", rsp_decode_error, want.decode_error);
         end
      end
   end

   // stimulus
   initial begin : stimulus
      logic [7:0] chars[$];
      int         n_elems;
      int         r;
      bit         noise;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++)
         send_item(DIRECTED_ROWS[i].in_byte, DIRECTED_ROWS[i].eos,
                   DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].res);

      while (bytes_sent < NUM_ITEMS) begin
         // quiet stretch with no idling, long hold-off inside it
         tx_idle_pct = (bytes_sent >= 500 && bytes_sent < 800) ? 0 : IDLE_PCT;
         rx_idle_pct = tx_idle_pct;
         if (bytes_sent >= 600) hold_go = 1'b1;

         chars.delete();
         noise   = ($urandom_range(99) < 8);
         n_elems = $urandom_range(1, 10);
         for (int e = 0; e < n_elems; e++) begin
            r = $urandom_range(99);
            if (noise) begin
               chars.push_back(8'($urandom_range(255)));
            end else if (r < 45) begin
               chars.push_back(8'($urandom_range(255)));
               if (chars[$] == url_pct_pkg::CHAR_PERCENT) chars[$] = url_pct_pkg::CHAR_PLUS;
            end else if (r < 55) begin
               chars.push_back(url_pct_pkg::CHAR_PLUS);
            end else if (r < 95) begin
               chars.push_back(url_pct_pkg::CHAR_PERCENT);
               chars.push_back(rand_hex_digit());
               chars.push_back(rand_hex_digit());
            end else begin
               // broken escape: bad first or second digit
               chars.push_back(url_pct_pkg::CHAR_PERCENT);
               if ($urandom_range(1)) chars.push_back(rand_hex_digit());
               chars.push_back(rand_non_hex());
            end
         end
         // now and then the string stops inside an escape
         if (!noise && $urandom_range(99) < 4) begin
            chars.push_back(url_pct_pkg::CHAR_PERCENT);
            if ($urandom_range(1)) chars.push_back(rand_hex_digit());
         end
         foreach (chars[i])
            send_item(chars[i], i == chars.size() - 1, ROW_PREDICT, NO_ITEM);
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("[url_percent_decoder] OK");
      end else begin
         $display("[url_percent_decoder] ERROR");
      end
      $finish;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("[url_percent_decoder] ERROR");
      $finish;
   end

endmodule
